FILE: design/mpio_pkg.sv
package mpio_pkg;

    localparam int MAX_INTERVALS_DEF = 1024;
    localparam int COORD_WIDTH_DEF   = 32;
    localparam int FIELD_W           = 32;
    localparam int LEN_W             = 33;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SORT_INIT,
        OP_PASS_INIT,
        OP_BLK_INIT,
        OP_PASS_END,
        OP_BLK_END,
        OP_MRG_WR,
        OP_SRCH_INIT,
        OP_PUSH,
        OP_POP,
        OP_PIV_STEP,
        OP_CRS_INIT,
        OP_CRS_STEP,
        OP_GO_RIGHT,
        OP_CLEAR
    } t_dp_op;

    typedef struct packed {
        logic   load;
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic pass_more;
        logic blk_more;
        logic mrg_done;
        logic span_big;
        logic stack_empty;
        logic piv_done;
        logic crs_done;
    } t_dp_status;

endpackage

FILE: design/mpio_ifs.sv
interface mpio_in_if import mpio_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] interval_low;
    logic signed [FIELD_W-1:0] interval_high;
    logic                      last_item;

    modport source(output valid, output interval_low, output interval_high,
                   output last_item, input ready);
    modport sink(input valid, input interval_low, input interval_high,
                 input last_item, output ready);
endinterface

interface mpio_out_if import mpio_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      overlap_found;
    logic        [LEN_W-1:0]   overlap_length;
    logic signed [FIELD_W-1:0] overlap_low;
    logic signed [FIELD_W-1:0] overlap_high;
    logic                      overflowed;

    modport source(output valid, output overlap_found, output overlap_length,
                   output overlap_low, output overlap_high, output overflowed,
                   input ready);
    modport sink(input valid, input overlap_found, input overlap_length,
                 input overlap_low, input overlap_high, input overflowed,
                 output ready);
endinterface

FILE: design/mpio_ctrl.sv
module mpio_ctrl import mpio_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_last,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_in_ready,
    output logic       o_out_valid
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_SORT_INIT,
        S_PASS_CHK,
        S_BLK_CHK,
        S_MRG_RD,
        S_MRG_WR,
        S_SRCH_INIT,
        S_DESC,
        S_PIV_RD,
        S_PIV_WR,
        S_CRS_RD,
        S_CRS_WR,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   load;
    t_dp_op op;

    always_comb begin
        n_state = r_state;
        op      = OP_NONE;
        load    = i_in_valid & r_in_ready;
        unique case (r_state)
            S_LOAD: begin
                if (load && i_last) n_state = S_SORT_INIT;
            end
            S_SORT_INIT: begin
                op      = OP_SORT_INIT;
                n_state = S_PASS_CHK;
            end
            S_PASS_CHK: begin
                if (i_status.pass_more) begin
                    op      = OP_PASS_INIT;
                    n_state = S_BLK_CHK;
                end else begin
                    n_state = S_SRCH_INIT;
                end
            end
            S_BLK_CHK: begin
                if (i_status.blk_more) begin
                    op      = OP_BLK_INIT;
                    n_state = S_MRG_RD;
                end else begin
                    op      = OP_PASS_END;
                    n_state = S_PASS_CHK;
                end
            end
            S_MRG_RD: begin
                if (i_status.mrg_done) begin
                    op      = OP_BLK_END;
                    n_state = S_BLK_CHK;
                end else begin
                    n_state = S_MRG_WR;
                end
            end
            S_MRG_WR: begin
                op      = OP_MRG_WR;
                n_state = S_MRG_RD;
            end
            S_SRCH_INIT: begin
                op      = OP_SRCH_INIT;
                n_state = S_DESC;
            end
            S_DESC: begin
                if (i_status.span_big) begin
                    op = OP_PUSH;
                end else if (i_status.stack_empty) begin
                    n_state = S_OUT;
                end else begin
                    op      = OP_POP;
                    n_state = S_PIV_RD;
                end
            end
            S_PIV_RD: begin
                if (i_status.piv_done) begin
                    op      = OP_CRS_INIT;
                    n_state = S_CRS_RD;
                end else begin
                    n_state = S_PIV_WR;
                end
            end
            S_PIV_WR: begin
                op      = OP_PIV_STEP;
                n_state = S_PIV_RD;
            end
            S_CRS_RD: begin
                if (i_status.crs_done) begin
                    op      = OP_GO_RIGHT;
                    n_state = S_DESC;
                end else begin
                    n_state = S_CRS_WR;
                end
            end
            S_CRS_WR: begin
                op      = OP_CRS_STEP;
                n_state = S_CRS_RD;
            end
            S_OUT: begin
                if (i_out_ready && r_out_valid) begin
                    op      = OP_CLEAR;
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= (n_state == S_LOAD);
            r_out_valid <= (n_state == S_OUT);
        end
    end

    assign o_cmd.load  = load;
    assign o_cmd.op    = op;
    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule

FILE: design/mpio_dp.sv
module mpio_dp import mpio_pkg::*; #(
    parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    input  logic        [FIELD_W-1:0] i_low,
    input  logic        [FIELD_W-1:0] i_high,
    output t_dp_status                o_status,
    output logic                      o_found,
    output logic        [LEN_W-1:0]   o_length,
    output logic signed [FIELD_W-1:0] o_low,
    output logic signed [FIELD_W-1:0] o_high,
    output logic                      o_overflowed
);

    localparam int CW   = COORD_WIDTH;
    localparam int AW   = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int IW   = $clog2(MAX_INTERVALS + 1);
    localparam int XW   = IW + 2;
    localparam int SD   = $clog2(MAX_INTERVALS) + 1;
    localparam int SPW  = (SD > 1) ? $clog2(SD) : 1;
    localparam int SPCW = $clog2(SD + 1);

    logic [2*CW-1:0] mem_a [MAX_INTERVALS];
    logic [2*CW-1:0] mem_b [MAX_INTERVALS];
    logic [2*CW-1:0] r_ra0, r_ra1, r_rb0, r_rb1;

    logic [IW-1:0]   r_count;
    logic            r_ovf;
    logic            r_src;
    logic [XW-1:0]   r_width, r_start, r_mid, r_end, r_i, r_j, r_k;
    logic [XW-1:0]   r_b, r_e, r_m;
    logic [SPCW-1:0] r_sp;
    logic [2*XW-1:0] r_stack [SD];
    logic signed [CW-1:0] r_piv_lo, r_piv_hi;
    logic            r_pfirst;
    logic signed [CW-1:0] r_best_lo, r_best_hi;
    logic [CW:0]     r_best_len;

    logic [2*CW-1:0] rd0, rd1, wdata_m;
    logic signed [CW-1:0] lo0, hi0, lo1;
    logic            take_i;
    logic [XW-1:0]   count_x;
    logic [XW-1:0]   blk_mid, blk_end;
    logic [XW:0]     sum_cur, sum_pop;
    logic [SPCW-1:0] sp_dec;
    logic [XW-1:0]   pop_b, pop_e;
    logic signed [CW-1:0] m_lo, m_hi;
    logic signed [CW:0]   diff;
    logic [CW:0]     c_len;
    logic            can_store;
    logic            a_we, b_we;
    logic [AW-1:0]   a_waddr;
    logic [2*CW-1:0] a_wdata;

    assign rd0     = r_src ? r_rb0 : r_ra0;
    assign rd1     = r_src ? r_rb1 : r_ra1;
    assign lo0     = rd0[CW-1:0];
    assign hi0     = rd0[2*CW-1:CW];
    assign lo1     = rd1[CW-1:0];
    assign count_x = XW'(r_count);

    assign take_i  = (r_i < r_mid) && ((r_j >= r_end) || (lo0 <= lo1));
    assign wdata_m = take_i ? rd0 : rd1;

    assign blk_mid = ((r_start + r_width) > count_x) ? count_x : (r_start + r_width);
    assign blk_end = ((r_start + (r_width << 1)) > count_x) ? count_x
                                                            : (r_start + (r_width << 1));

    assign sum_cur = {1'b0, r_b} + {1'b0, r_e};
    assign sp_dec  = r_sp - SPCW'(1);
    assign {pop_b, pop_e} = r_stack[sp_dec[SPW-1:0]];
    assign sum_pop = {1'b0, pop_b} + {1'b0, pop_e};

    assign m_lo  = (r_piv_lo > lo0) ? r_piv_lo : lo0;
    assign m_hi  = (r_piv_hi < hi0) ? r_piv_hi : hi0;
    assign diff  = {m_hi[CW-1], m_hi} - {m_lo[CW-1], m_lo};
    assign c_len = (m_hi < m_lo) ? '0 : (CW + 1)'(diff) + (CW + 1)'(1);

    assign can_store = i_cmd.load && (r_count < IW'(MAX_INTERVALS));
    assign a_we      = can_store || ((i_cmd.op == OP_MRG_WR) && r_src);
    assign b_we      = (i_cmd.op == OP_MRG_WR) && !r_src;
    assign a_waddr   = can_store ? r_count[AW-1:0] : r_k[AW-1:0];
    assign a_wdata   = can_store ? {i_high[CW-1:0], i_low[CW-1:0]} : wdata_m;

    always_ff @(posedge i_clk) begin
        if (a_we) mem_a[a_waddr] <= a_wdata;
        if (b_we) mem_b[r_k[AW-1:0]] <= wdata_m;
        r_ra0 <= mem_a[r_i[AW-1:0]];
        r_ra1 <= mem_a[r_j[AW-1:0]];
        r_rb0 <= mem_b[r_i[AW-1:0]];
        r_rb1 <= mem_b[r_j[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_sp    <= '0;
        end else begin
            if (i_cmd.load) begin
                if (can_store) r_count <= r_count + IW'(1);
                else           r_ovf   <= 1'b1;
            end
            case (i_cmd.op)
                OP_SORT_INIT: begin
                    r_width <= XW'(1);
                    r_src   <= 1'b0;
                end
                OP_PASS_INIT: r_start <= '0;
                OP_BLK_INIT: begin
                    r_mid <= blk_mid;
                    r_end <= blk_end;
                    r_i   <= r_start;
                    r_j   <= blk_mid;
                    r_k   <= r_start;
                end
                OP_PASS_END: begin
                    r_src   <= ~r_src;
                    r_width <= r_width << 1;
                end
                OP_BLK_END: r_start <= r_start + (r_width << 1);
                OP_MRG_WR: begin
                    r_k <= r_k + XW'(1);
                    if (take_i) r_i <= r_i + XW'(1);
                    else        r_j <= r_j + XW'(1);
                end
                OP_SRCH_INIT: begin
                    r_b        <= '0;
                    r_e        <= count_x;
                    r_sp       <= '0;
                    r_best_lo  <= '0;
                    r_best_hi  <= '1;
                    r_best_len <= '0;
                end
                OP_PUSH: begin
                    r_stack[r_sp[SPW-1:0]] <= {r_b, r_e};
                    r_sp <= r_sp + SPCW'(1);
                    r_e  <= sum_cur[XW:1];
                end
                OP_POP: begin
                    r_sp     <= sp_dec;
                    r_b      <= pop_b;
                    r_e      <= pop_e;
                    r_m      <= sum_pop[XW:1];
                    r_i      <= pop_b;
                    r_pfirst <= 1'b1;
                end
                OP_PIV_STEP: begin
                    if (r_pfirst || (hi0 > r_piv_hi)) begin
                        r_piv_lo <= lo0;
                        r_piv_hi <= hi0;
                    end
                    r_pfirst <= 1'b0;
                    r_i      <= r_i + XW'(1);
                end
                OP_CRS_INIT: r_i <= r_m;
                OP_CRS_STEP: begin
                    if (c_len > r_best_len) begin
                        r_best_lo  <= m_lo;
                        r_best_hi  <= m_hi;
                        r_best_len <= c_len;
                    end
                    r_i <= r_i + XW'(1);
                end
                OP_GO_RIGHT: r_b <= r_m;
                OP_CLEAR: begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign o_status.pass_more   = (r_width < count_x);
    assign o_status.blk_more    = (r_start < count_x);
    assign o_status.mrg_done    = (r_k == r_end);
    assign o_status.span_big    = ((r_e - r_b) >= XW'(2));
    assign o_status.stack_empty = (r_sp == '0);
    assign o_status.piv_done    = (r_i == r_m);
    assign o_status.crs_done    = (r_i == r_e);

    assign o_found      = (r_best_len != '0);
    assign o_length     = LEN_W'(r_best_len);
    assign o_low        = FIELD_W'(r_best_lo);
    assign o_high       = FIELD_W'(r_best_hi);
    assign o_overflowed = r_ovf;

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPCW'(SD))
        else $error("search stack overrun");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= IW'(MAX_INTERVALS))
        else $error("interval count beyond capacity");

    a_drop_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && (r_count == IW'(MAX_INTERVALS))) |=> r_ovf)
        else $error("dropped interval not flagged");

endmodule

FILE: design/max_pairwise_interval_overlap.sv
// Channel  Dir  Fields
// i_in     in   interval_low, interval_high, last_item
// o_res    out  overlap_found, overlap_length, overlap_low, overlap_high, overflowed
//
// Intervals load at one per cycle into an on-chip memory until last_item.
// The merge sort then runs bottom-up passes of doubling width, reading and then writing each element.
// The search then splits the sorted list with a span stack and scans each span through one read port.
// No input request is accepted from last_item until the result request is taken.
// Reset is synchronous and active low; the memories need no clearing pass.
module max_pairwise_interval_overlap import mpio_pkg::*; #(
    parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mpio_in_if.sink     i_in,
    mpio_out_if.source  o_res
);

    t_dp_cmd    cmd;
    t_dp_status status;

    mpio_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_last      (i_in.last_item),
        .i_out_ready (o_res.ready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_res.valid)
    );

    mpio_dp #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .COORD_WIDTH   (COORD_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_low        (i_in.interval_low),
        .i_high       (i_in.interval_high),
        .o_status     (status),
        .o_found      (o_res.overlap_found),
        .o_length     (o_res.overlap_length),
        .o_low        (o_res.overlap_low),
        .o_high       (o_res.overlap_high),
        .o_overflowed (o_res.overflowed)
    );

endmodule
